FILE: rtl/sample_ring_fifo_peek_discard_assert.svh
// Assertion macros used by the sample ring FIFO controller.
`ifndef SAMPLE_RING_FIFO_PEEK_DISCARD_ASSERT_SVH
`define SAMPLE_RING_FIFO_PEEK_DISCARD_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define SRFPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("srfpd: same-cycle check failed");

// Next-cycle implication, checked while out of reset.
`define SRFPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("srfpd: next-cycle check failed");

`endif

FILE: rtl/srfpd_pkg.sv
// Package: command and result types, op codes and fixed field widths.
`default_nettype none

package srfpd_pkg;

  localparam int ROW_DATA_W = 64;
  localparam int AMOUNT_W   = 9;
  localparam int BCNT_W     = 7;
  localparam int PEND_W     = 9;
  localparam int DROP_W     = 32;

  typedef enum logic [2:0] {
    OP_PUSH    = 3'd0,
    OP_COPY    = 3'd1,
    OP_DISCARD = 3'd2,
    OP_BEGIN   = 3'd3,
    OP_STOP    = 3'd4,
    OP_FINISH  = 3'd5,
    OP_STATUS  = 3'd6
  } op_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_BATCH = 1'b1
  } state_e;

  typedef struct packed {
    op_e                   op;
    logic [ROW_DATA_W-1:0] sample_row;
    logic [AMOUNT_W-1:0]   amount;
  } cmd_t;

  typedef struct packed {
    logic [ROW_DATA_W-1:0] row_data;
    logic                  row_valid;
    logic                  last;
    logic [BCNT_W-1:0]     batch_count;
    logic [PEND_W-1:0]     pending_count;
    logic [DROP_W-1:0]     dropped_count;
    logic                  accepting;
  } res_t;

  // Result fields other than the row itself, built by the controller
  typedef struct packed {
    logic              row_valid;
    logic              last;
    logic [BCNT_W-1:0] batch_count;
    logic [PEND_W-1:0] pending_count;
    logic [DROP_W-1:0] dropped_count;
    logic              accepting;
  } meta_t;

endpackage

`default_nettype wire

FILE: rtl/srfpd_mem.sv
// Row store: one write port, one read port with registered read data.
`default_nettype none

module srfpd_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write the tail row, and register the requested row as read data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/srfpd_ctrl.sv
// Controller: pointers, fill level, drop tally, gate and the batch read sequencer.
`default_nettype none
`include "sample_ring_fifo_peek_discard_assert.svh"

module srfpd_ctrl #(
  parameter int DEPTH     = 256,
  parameter int MAX_BATCH = 64,
  parameter int ROW_W     = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start,
  output logic                          busy,
  input  wire srfpd_pkg::cmd_t          cmd_i,
  output logic                          mem_we_o,
  output logic      [$clog2(DEPTH)-1:0] mem_waddr_o,
  output logic      [ROW_W-1:0]         mem_wdata_o,
  output logic                          mem_re_o,
  output logic      [$clog2(DEPTH)-1:0] mem_raddr_o,
  output logic                          strobe_o,
  output srfpd_pkg::meta_t              meta_o
);

  localparam int PTR_W  = $clog2(DEPTH);
  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int CMP_W  = (FILL_W > srfpd_pkg::AMOUNT_W) ? FILL_W : srfpd_pkg::AMOUNT_W;
  localparam int BW     = srfpd_pkg::BCNT_W;
  localparam logic [FILL_W-1:0] DEPTH_F   = FILL_W'(DEPTH);
  localparam logic [FILL_W:0]   DEPTH_S   = (FILL_W + 1)'(DEPTH);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(DEPTH - 1);
  localparam logic [CMP_W-1:0]  MAX_B_C   = CMP_W'(MAX_BATCH);

  srfpd_pkg::state_e        state_q, state_d;
  logic [PTR_W-1:0]         rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]         wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]         raddr_q, raddr_d;
  logic [FILL_W-1:0]        fill_q, fill_d;
  logic [srfpd_pkg::DROP_W-1:0] drop_q, drop_d;
  logic                     gate_q, gate_d;
  logic [BW-1:0]            n_q, n_d;
  logic [BW-1:0]            iss_q, iss_d;
  logic                     strobe_q, strobe_d;
  srfpd_pkg::meta_t         meta_q, meta_d;

  logic                     accept;
  logic [CMP_W-1:0]         amt_c;
  logic [CMP_W-1:0]         fill_c;
  logic [CMP_W-1:0]         min_af;
  logic [BW-1:0]            batch_n;
  logic [FILL_W-1:0]        disc_n;
  logic [FILL_W:0]          disc_sum;
  logic [PTR_W-1:0]         disc_ptr;
  logic [PTR_W-1:0]         rd_ptr_inc;
  logic [PTR_W-1:0]         wr_ptr_inc;
  logic [PTR_W-1:0]         raddr_inc;

  assign accept = start && (state_q == srfpd_pkg::ST_IDLE);
  assign busy   = (state_q == srfpd_pkg::ST_BATCH);

  // Clip the amount to what is pending, then to the batch limit
  assign amt_c   = CMP_W'(cmd_i.amount);
  assign fill_c  = CMP_W'(fill_q);
  assign min_af  = (amt_c < fill_c) ? amt_c : fill_c;
  assign batch_n = (min_af > MAX_B_C) ? BW'(MAX_BATCH) : BW'(min_af);

  // Advance the head by the discard count, wrapping once at most
  assign disc_n   = FILL_W'(min_af);
  assign disc_sum = (FILL_W + 1)'(rd_ptr_q) + (FILL_W + 1)'(disc_n);
  assign disc_ptr = (disc_sum >= DEPTH_S) ? PTR_W'(disc_sum - DEPTH_S) : PTR_W'(disc_sum);

  assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
  assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
  assign raddr_inc  = (raddr_q == PTR_LAST) ? '0 : raddr_q + PTR_W'(1);

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= srfpd_pkg::ST_IDLE;
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      raddr_q  <= '0;
      fill_q   <= '0;
      drop_q   <= '0;
      gate_q   <= 1'b0;
      n_q      <= '0;
      iss_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      raddr_q  <= raddr_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      gate_q   <= gate_d;
      n_q      <= n_d;
      iss_q    <= iss_d;
      strobe_q <= strobe_d;
    end
  end

  // Result fields travel with the strobe
  always_ff @(posedge clk_i) begin
    meta_q <= meta_d;
  end

  // Next state: execute the accepted op or issue the next batch read
  always_comb begin
    state_d  = state_q;
    rd_ptr_d = rd_ptr_q;
    wr_ptr_d = wr_ptr_q;
    raddr_d  = raddr_q;
    fill_d   = fill_q;
    drop_d   = drop_q;
    gate_d   = gate_q;
    n_d      = n_q;
    iss_d    = iss_q;
    strobe_d = 1'b0;
    meta_d   = meta_q;

    mem_we_o    = 1'b0;
    mem_waddr_o = wr_ptr_q;
    mem_wdata_o = cmd_i.sample_row[ROW_W-1:0];
    mem_re_o    = 1'b0;
    mem_raddr_o = raddr_q;

    case (state_q)
      srfpd_pkg::ST_IDLE: begin
        if (accept) begin
          strobe_d           = 1'b1;
          meta_d.row_valid   = 1'b0;
          meta_d.last        = 1'b1;
          meta_d.batch_count = '0;
          case (cmd_i.op)
            srfpd_pkg::OP_PUSH: begin
              if (gate_q) begin
                if (fill_q == DEPTH_F) begin
                  drop_d = drop_q + srfpd_pkg::DROP_W'(1);
                end else begin
                  mem_we_o = 1'b1;
                  wr_ptr_d = wr_ptr_inc;
                  fill_d   = fill_q + FILL_W'(1);
                end
              end
            end
            srfpd_pkg::OP_COPY: begin
              if (batch_n != '0) begin
                mem_re_o           = 1'b1;
                mem_raddr_o        = rd_ptr_q;
                raddr_d            = rd_ptr_inc;
                n_d                = batch_n;
                iss_d              = BW'(1);
                meta_d.row_valid   = 1'b1;
                meta_d.last        = (batch_n == BW'(1));
                meta_d.batch_count = batch_n;
                if (batch_n != BW'(1)) begin
                  state_d = srfpd_pkg::ST_BATCH;
                end
              end
            end
            srfpd_pkg::OP_DISCARD: begin
              rd_ptr_d = disc_ptr;
              fill_d   = fill_q - disc_n;
            end
            srfpd_pkg::OP_BEGIN: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              fill_d   = '0;
              drop_d   = '0;
              gate_d   = 1'b1;
            end
            srfpd_pkg::OP_STOP: begin
              gate_d = 1'b0;
            end
            srfpd_pkg::OP_FINISH: begin
              rd_ptr_d = '0;
              wr_ptr_d = '0;
              fill_d   = '0;
              gate_d   = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      srfpd_pkg::ST_BATCH: begin
        // Issue one row read a cycle until the run is complete
        mem_re_o           = 1'b1;
        raddr_d            = raddr_inc;
        iss_d              = iss_q + BW'(1);
        strobe_d           = 1'b1;
        meta_d.row_valid   = 1'b1;
        meta_d.last        = (iss_d == n_q);
        meta_d.batch_count = n_q;
        if (iss_d == n_q) begin
          state_d = srfpd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = srfpd_pkg::ST_IDLE;
      end
    endcase

    // Report the queue state as it stands after this beat
    if (strobe_d) begin
      meta_d.pending_count = srfpd_pkg::PEND_W'(fill_d);
      meta_d.dropped_count = drop_d;
      meta_d.accepting     = gate_d;
    end
  end

  assign strobe_o = strobe_q;
  assign meta_o   = meta_q;

  `SRFPD_ASSERT_NOW(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= DEPTH_F)
  `SRFPD_ASSERT_NOW(a_batch_count, clk_i, rst_ni, state_q == srfpd_pkg::ST_BATCH, iss_q < n_q)
  `SRFPD_ASSERT_NEXT(a_read_beat, clk_i, rst_ni, mem_re_o, strobe_q && meta_q.row_valid)
  `SRFPD_ASSERT_NEXT(a_batch_hold, clk_i, rst_ni, state_q == srfpd_pkg::ST_BATCH, $stable(fill_q) && $stable(rd_ptr_q))

endmodule

`default_nettype wire

FILE: rtl/sample_ring_fifo_peek_discard.sv
// Top level: ring FIFO of sample rows with peek, discard, gate and drop tally.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------
//  command  | start, busy        | cmd_i  (op, sample_row, amount)
//  result   | res_strobe_o       | res_o  (row, flags, counts, gate)
//
// Every op other than copy_batch takes one cycle; a new command may be taken
// in the very next cycle, and its single result beat shows one cycle after it.
// A copy_batch of n rows reads the row store once a cycle; busy is high while
// the later reads issue, and its n beats begin in the cycle after the accept.
// Reset clears pointers, fill level, drop tally and gate; the row store needs
// no clearing pass. The receiver cannot stall: each beat is shown once.
`default_nettype none

module sample_ring_fifo_peek_discard #(
  parameter int DEPTH     = 256,
  parameter int CHANNELS  = 8,
  parameter int MAX_BATCH = 64
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire srfpd_pkg::cmd_t cmd_i,
  output logic                 res_strobe_o,
  output srfpd_pkg::res_t      res_o
);

  localparam int ROW_W = CHANNELS * 8;
  localparam int PTR_W = $clog2(DEPTH);

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [ROW_W-1:0] mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic [ROW_W-1:0] mem_rdata;
  srfpd_pkg::meta_t meta;

  srfpd_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_BATCH (MAX_BATCH),
    .ROW_W     (ROW_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .strobe_o    (res_strobe_o),
    .meta_o      (meta)
  );

  srfpd_mem #(
    .DEPTH (DEPTH),
    .WIDTH (ROW_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Assemble the beat: the row only when it comes from the store
  always_comb begin
    res_o.row_data      = meta.row_valid ? srfpd_pkg::ROW_DATA_W'(mem_rdata) : '0;
    res_o.row_valid     = meta.row_valid;
    res_o.last          = meta.last;
    res_o.batch_count   = meta.batch_count;
    res_o.pending_count = meta.pending_count;
    res_o.dropped_count = meta.dropped_count;
    res_o.accepting     = meta.accepting;
  end

endmodule

`default_nettype wire
